### rtl/core/cmc_pkg.sv
// shared types, state codes and helper functions of the cooling mode controller
`timescale 1ns / 1ps

package cmc_pkg;

	localparam logic [2:0] ST_OFF      = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_COOLING  = 3'd2;
	localparam logic [2:0] ST_SUSPECT  = 3'd3;
	localparam logic [2:0] ST_PAUSED   = 3'd4;
	localparam logic [2:0] ST_RECOVERY = 3'd5;
	localparam logic [2:0] ST_MANUAL   = 3'd6;

	localparam logic [2:0] REG_PAUSE_DELAY    = 3'd0;
	localparam logic [2:0] REG_RECOVERY_DELAY = 3'd1;
	localparam logic [2:0] REG_HUMIDITY_RISE  = 3'd2;
	localparam logic [2:0] REG_SETPOINT_LOW   = 3'd3;
	localparam logic [2:0] REG_SETPOINT_HIGH  = 3'd4;

	localparam logic [15:0] PAUSE_DELAY_RST    = 16'd5000;
	localparam logic [15:0] RECOVERY_DELAY_RST = 16'd5000;
	localparam logic [9:0]  HUMIDITY_RISE_RST  = 10'd100;
	localparam logic [5:0]  SETPOINT_LOW_RST   = 6'd16;
	localparam logic [5:0]  SETPOINT_HIGH_RST  = 6'd30;
	localparam logic [5:0]  SETPOINT_RST       = 6'd24;

	typedef struct packed {
		logic        sensor_present;
		logic        contact_open;
		logic        reading_valid;
		logic [10:0] temperature_tenths;
		logic [9:0]  humidity_tenths;
		logic [3:0]  button_events;
		logic [31:0] time_ms;
	} step_t;

	typedef struct packed {
		logic [2:0] ac_state;
		logic [1:0] fan_level;
		logic [7:0] rounded_temperature;
		logic [5:0] current_setpoint;
	} result_t;

	// cooling level from temperature minus ten times the setpoint
	function automatic logic [1:0] level_of(input logic signed [12:0] delta,
		input logic manual);
		logic [1:0] lvl;
		if ((!manual && delta <= 13'sd10) || (manual && delta <= 13'sd0)) begin
			lvl = 2'd0;
		end else if (delta <= 13'sd20) begin
			lvl = 2'd1;
		end else if (delta <= 13'sd40) begin
			lvl = 2'd2;
		end else begin
			lvl = 2'd3;
		end
		return lvl;
	endfunction

	// whole degrees, half away from zero; divide by ten as multiply by 6554 / 2^16
	function automatic logic [7:0] round_whole(input logic signed [10:0] t);
		logic [10:0] mag;
		logic [11:0] biased;
		logic [24:0] prod;
		logic [7:0]  q;
		mag    = t[10] ? (11'd0 - t) : t;
		biased = {1'b0, mag} + 12'd5;
		prod   = {13'd0, biased} * 25'd6554;
		q      = prod[23:16];
		return t[10] ? (8'd0 - q) : q;
	endfunction

endpackage

### rtl/core/cooling_mode_controller_top.sv
// cooling mode controller: input register, one-pass step logic, result register
`timescale 1ns / 1ps

// Takes one control step per clock unless the output stalls, and returns one
// result per step by way of the step register, then the result register. The state is
// updated at the same edge the result register loads, so the next step, held in
// the step register, always sees it. Input tready drops only while a step waits
// in the step register and a result waits that the sink does not take.
// Configuration writes over the register port belong between steps when the
// block is idle; registers sit at byte addresses 0, 4, 8, 12 and 16.
module cooling_mode_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// contact_open, temperature_tenths[11:1], humidity_tenths, button_events,
	// time_ms[57:26], zero fill
	input  logic [63:0] s_tdata,
	// sensor_present, reading_valid
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// ac_state, fan_level, rounded_temperature, current_setpoint, zero fill
	output logic [23:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] pause_delay_q;
	logic [15:0] recovery_delay_q;
	logic [9:0]  humidity_rise_q;
	logic [5:0]  setpoint_low_q;
	logic [5:0]  setpoint_high_q;

	logic        power_q;
	logic        manual_q;
	logic        seen_q;
	logic        win_seen_q;
	logic        pause_q;
	logic [5:0]  setpoint_q;
	logic [10:0] last_temp_q;
	logic [9:0]  last_hum_q;
	logic [9:0]  hum_open_q;
	logic [31:0] open_time_q;
	logic [31:0] rec_start_q;
	logic [2:0]  mode_q;

	logic              valid_s1;
	cmc_pkg::step_t    step_s1;
	cmc_pkg::result_t  res_q;
	logic              out_valid_q;

	logic advance;
	logic fire;
	logic cfg_wr;

	logic        power_n, manual_n, seen_n, win_seen_n, pause_n, win_final;
	logic [5:0]  sp_up, setpoint_n;
	logic [10:0] last_temp_n;
	logic [9:0]  last_hum_n, hum_open_n;
	logic [31:0] open_time_n, rec_start_n;
	logic [2:0]  mode_n;
	logic [1:0]  level_n;
	logic        opening;
	logic [31:0] open_ms, rec_ms;
	logic signed [11:0] hum_diff;
	logic        rise;
	logic signed [12:0] delta;
	logic [1:0]  auto_lvl, man_lvl;
	logic [3:0]  ev;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign advance = !out_valid_q || m_tready;
	assign fire    = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, res_q.current_setpoint, res_q.rounded_temperature,
		res_q.fan_level, res_q.ac_state};

	always_comb begin
		case (paddr[4:2])
			cmc_pkg::REG_PAUSE_DELAY:    prdata = {16'd0, pause_delay_q};
			cmc_pkg::REG_RECOVERY_DELAY: prdata = {16'd0, recovery_delay_q};
			cmc_pkg::REG_HUMIDITY_RISE:  prdata = {22'd0, humidity_rise_q};
			cmc_pkg::REG_SETPOINT_LOW:   prdata = {26'd0, setpoint_low_q};
			cmc_pkg::REG_SETPOINT_HIGH:  prdata = {26'd0, setpoint_high_q};
			default:                     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pause_delay_q    <= cmc_pkg::PAUSE_DELAY_RST;
			recovery_delay_q <= cmc_pkg::RECOVERY_DELAY_RST;
			humidity_rise_q  <= cmc_pkg::HUMIDITY_RISE_RST;
			setpoint_low_q   <= cmc_pkg::SETPOINT_LOW_RST;
			setpoint_high_q  <= cmc_pkg::SETPOINT_HIGH_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				cmc_pkg::REG_PAUSE_DELAY:    pause_delay_q    <= pwdata[15:0];
				cmc_pkg::REG_RECOVERY_DELAY: recovery_delay_q <= pwdata[15:0];
				cmc_pkg::REG_HUMIDITY_RISE:  humidity_rise_q  <= pwdata[9:0];
				cmc_pkg::REG_SETPOINT_LOW:   setpoint_low_q   <= pwdata[5:0];
				cmc_pkg::REG_SETPOINT_HIGH:  setpoint_high_q  <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			step_s1.sensor_present     <= s_tuser[0];
			step_s1.reading_valid      <= s_tuser[1];
			step_s1.contact_open       <= s_tdata[0];
			step_s1.temperature_tenths <= s_tdata[11:1];
			step_s1.humidity_tenths    <= s_tdata[21:12];
			step_s1.button_events      <= s_tdata[25:22];
			step_s1.time_ms            <= s_tdata[57:26];
		end
	end

	// step logic
	always_comb begin
		ev = step_s1.button_events;

		power_n    = power_q ^ ev[3];
		manual_n   = manual_q;
		pause_n    = pause_q;
		win_seen_n = win_seen_q;
		if (ev[3] && !power_n) begin
			manual_n   = 1'b0;
			pause_n    = 1'b0;
			win_seen_n = 1'b0;
		end

		sp_up = (ev[0] && (setpoint_q < setpoint_high_q)) ?
			(setpoint_q + 6'd1) : setpoint_q;
		setpoint_n = (ev[1] && (sp_up > setpoint_low_q)) ? (sp_up - 6'd1) : sp_up;

		if (ev[2] && power_n) begin
			manual_n = !manual_n;
			if (manual_n) begin
				pause_n = 1'b0;
			end
		end

		opening     = step_s1.sensor_present && step_s1.contact_open && !win_seen_n;
		open_time_n = opening ? step_s1.time_ms : open_time_q;
		hum_open_n  = opening ? (seen_q ? last_hum_q : step_s1.humidity_tenths) :
			hum_open_q;

		if (step_s1.sensor_present && step_s1.reading_valid) begin
			last_temp_n = step_s1.temperature_tenths;
			last_hum_n  = step_s1.humidity_tenths;
			seen_n      = 1'b1;
		end else begin
			last_temp_n = last_temp_q;
			last_hum_n  = last_hum_q;
			seen_n      = seen_q;
		end

		open_ms  = step_s1.time_ms - open_time_n;
		rec_ms   = step_s1.time_ms - rec_start_q;
		hum_diff = $signed({2'b00, step_s1.humidity_tenths})
			- $signed({2'b00, hum_open_n});
		rise     = step_s1.reading_valid && (hum_diff >= $signed({2'b00, humidity_rise_q}));

		delta    = $signed({{2{last_temp_n[10]}}, last_temp_n})
			- $signed({4'b0000, setpoint_n, 3'b000}) - $signed({6'b000000, setpoint_n, 1'b0});
		auto_lvl = cmc_pkg::level_of(delta, 1'b0);
		man_lvl  = cmc_pkg::level_of(delta, 1'b1);

		rec_start_n = rec_start_q;
		if (!power_n) begin
			mode_n = cmc_pkg::ST_OFF;
		end else if (manual_n) begin
			mode_n = cmc_pkg::ST_MANUAL;
		end else if (step_s1.sensor_present && step_s1.contact_open) begin
			if ((open_ms >= {16'd0, pause_delay_q}) || rise || pause_n) begin
				pause_n = 1'b1;
				mode_n  = cmc_pkg::ST_PAUSED;
			end else begin
				mode_n = cmc_pkg::ST_SUSPECT;
			end
		end else if (win_seen_n) begin
			rec_start_n = step_s1.time_ms;
			pause_n     = 1'b0;
			mode_n      = cmc_pkg::ST_RECOVERY;
		end else if ((mode_q == cmc_pkg::ST_RECOVERY) &&
			(rec_ms < {16'd0, recovery_delay_q})) begin
			mode_n = cmc_pkg::ST_RECOVERY;
		end else if (seen_n && (auto_lvl != 2'd0)) begin
			mode_n = cmc_pkg::ST_COOLING;
		end else begin
			mode_n = cmc_pkg::ST_IDLE;
		end

		win_final = step_s1.sensor_present ? step_s1.contact_open : win_seen_n;

		if (mode_n == cmc_pkg::ST_COOLING) begin
			level_n = auto_lvl;
		end else if (mode_n == cmc_pkg::ST_MANUAL) begin
			level_n = man_lvl;
		end else begin
			level_n = 2'd0;
		end
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q     <= 1'b0;
			manual_q    <= 1'b0;
			seen_q      <= 1'b0;
			win_seen_q  <= 1'b0;
			pause_q     <= 1'b0;
			setpoint_q  <= cmc_pkg::SETPOINT_RST;
			last_temp_q <= 11'd0;
			last_hum_q  <= 10'd0;
			hum_open_q  <= 10'd0;
			open_time_q <= 32'd0;
			rec_start_q <= 32'd0;
			mode_q      <= cmc_pkg::ST_OFF;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				power_q     <= power_n;
				manual_q    <= manual_n;
				seen_q      <= seen_n;
				win_seen_q  <= win_final;
				pause_q     <= pause_n;
				setpoint_q  <= setpoint_n;
				last_temp_q <= last_temp_n;
				last_hum_q  <= last_hum_n;
				hum_open_q  <= hum_open_n;
				open_time_q <= open_time_n;
				rec_start_q <= rec_start_n;
				mode_q      <= mode_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.ac_state            <= mode_n;
			res_q.fan_level           <= level_n;
			res_q.rounded_temperature <= seen_n ?
				cmc_pkg::round_whole(last_temp_n) : 8'd0;
			res_q.current_setpoint    <= setpoint_n;
		end
	end

`ifndef SYNTHESIS
	a_level_only_when_active: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.fan_level != 2'd0) |->
		(res_q.ac_state == cmc_pkg::ST_COOLING || res_q.ac_state == cmc_pkg::ST_MANUAL))
		else $error("cooling level nonzero outside cooling or manual");

	a_off_means_unpowered: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> ((mode_q == cmc_pkg::ST_OFF) == !power_q))
		else $error("off state disagrees with power flag");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a full pipeline");

	a_result_follows_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed step produced no result");
`endif

endmodule
